FILE: rtl/cbsub_pkg.sv
// Shared types and constants of the cubic Bezier subdivider.
// No dependencies; every other file of the block imports this package.
package cbsub_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int T_FRAC_BITS = 16;
	localparam int T_WIDTH = T_FRAC_BITS + 1;
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// one input item: four control points and the split parameter
	typedef struct packed {
		coord_t p0_x;
		coord_t p0_y;
		coord_t p1_x;
		coord_t p1_y;
		coord_t p2_x;
		coord_t p2_y;
		coord_t p3_x;
		coord_t p3_y;
		logic [T_WIDTH-1:0] split_t;
	} req_t;

	// one result item
	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic half;
		logic [1:0] point_index;
		logic ok;
		logic last;
	} point_t;

	// queue entry: the item plus its classification
	typedef struct packed {
		req_t req;
		logic ok;
	} qent_t;

	// values that ride along the lerp pipeline, index 0 is x, 1 is y
	typedef struct packed {
		coord_t [1:0] p0;
		coord_t [1:0] p3;
		coord_t [1:0] a1;
		coord_t [1:0] c1;
		coord_t [1:0] a2;
		coord_t [1:0] b2;
		logic [T_FRAC_BITS-1:0] t;
		logic ok;
	} side_t;

endpackage

FILE: rtl/cbsub_front.sv
// Front end: takes input items, classifies the split parameter and queues them.
// Depends on cbsub_pkg.
module cbsub_front import cbsub_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  req_t  req,
	output logic  busy,
	input  logic  pop,
	output logic  q_valid,
	output qent_t q_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qent_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             split_ok;

	// valid split only strictly inside (0, one)
	assign split_ok = !req.split_t[T_FRAC_BITS] && (|req.split_t[T_FRAC_BITS-1:0]);

	assign busy    = (cnt_q == CNT_W'(DEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{req: req, ok: split_ok};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("queue popped while empty");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !pop) |=> (cnt_q == CNT_W'(DEPTH)))
		else $error("queue fill level moved while full and not drained");

endmodule

FILE: rtl/cbsub_lerp.sv
// One fixed-point lerp unit, a + floor(t * (b - a) / one), three stages.
// Depends on cbsub_pkg.
module cbsub_lerp import cbsub_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  coord_t                 a,
	input  coord_t                 b,
	input  logic [T_FRAC_BITS-1:0] t,
	output coord_t                 r
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = DW + T_FRAC_BITS + 1;

	logic signed [DW-1:0]   d_s1;
	coord_t                 a_s1;
	logic [T_FRAC_BITS-1:0] t_s1;
	logic signed [PW-1:0]   prod_s2;
	coord_t                 a_s2;
	coord_t                 res_s3;
	logic signed [PW-1:0]   sum;

	// arithmetic shift gives the floor
	assign sum = PW'(a_s2) + (prod_s2 >>> T_FRAC_BITS);
	assign r   = res_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= $signed({b[COORD_WIDTH-1], b}) - $signed({a[COORD_WIDTH-1], a});
			a_s1    <= a;
			t_s1    <= t;
			prod_s2 <= PW'(d_s1) * PW'($signed({1'b0, t_s1}));
			a_s2    <= a_s1;
			res_s3  <= sum[COORD_WIDTH-1:0];
		end
	end

endmodule

FILE: rtl/cbsub_back.sv
// Back end: de Casteljau lerp pipeline with a global advance, and the point emitter.
// Depends on cbsub_pkg and cbsub_lerp.
module cbsub_back import cbsub_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  qent_t  q_data,
	output logic   q_pop,
	output logic   point_valid,
	output point_t point
);

	qent_t        item_s0;
	side_t        side_s  [1:9];
	side_t        side_nx [2:9];
	logic [9:0]   vld_s;
	logic         adv;
	logic [2:0]   cnt_q;
	logic         last_w;
	point_t       sel;
	point_t       point_q;
	logic         point_valid_q;
	side_t        side_in;

	coord_t [1:0] p0_in, p1_in, p2_in, p3_in;
	coord_t [1:0] a1_w, b1_w, c1_w, a2_w, b2_w, m_w;

	assign p0_in = {item_s0.req.p0_y, item_s0.req.p0_x};
	assign p1_in = {item_s0.req.p1_y, item_s0.req.p1_x};
	assign p2_in = {item_s0.req.p2_y, item_s0.req.p2_x};
	assign p3_in = {item_s0.req.p3_y, item_s0.req.p3_x};

	for (genvar g = 0; g < 2; g++) begin : g_lane
		cbsub_lerp u_a1 (.clk, .en(adv), .a(p0_in[g]), .b(p1_in[g]),
			.t(item_s0.req.split_t[T_FRAC_BITS-1:0]), .r(a1_w[g]));
		cbsub_lerp u_b1 (.clk, .en(adv), .a(p1_in[g]), .b(p2_in[g]),
			.t(item_s0.req.split_t[T_FRAC_BITS-1:0]), .r(b1_w[g]));
		cbsub_lerp u_c1 (.clk, .en(adv), .a(p2_in[g]), .b(p3_in[g]),
			.t(item_s0.req.split_t[T_FRAC_BITS-1:0]), .r(c1_w[g]));
		cbsub_lerp u_a2 (.clk, .en(adv), .a(a1_w[g]), .b(b1_w[g]),
			.t(side_s[3].t), .r(a2_w[g]));
		cbsub_lerp u_b2 (.clk, .en(adv), .a(b1_w[g]), .b(c1_w[g]),
			.t(side_s[3].t), .r(b2_w[g]));
		cbsub_lerp u_m (.clk, .en(adv), .a(a2_w[g]), .b(b2_w[g]),
			.t(side_s[6].t), .r(m_w[g]));
	end

	always_comb begin
		side_in    = '0;
		side_in.p0 = p0_in;
		side_in.p3 = p3_in;
		side_in.t  = item_s0.req.split_t[T_FRAC_BITS-1:0];
		side_in.ok = item_s0.ok;
		for (int k = 2; k <= 9; k++) begin
			side_nx[k] = side_s[k-1];
		end
		// pick up the lerp results as their stage passes
		side_nx[4].a1 = a1_w;
		side_nx[4].c1 = c1_w;
		side_nx[7].a2 = a2_w;
		side_nx[7].b2 = b2_w;
	end

	// a failed split is a single result; a valid one runs eight points
	assign last_w = !side_s[9].ok || (cnt_q == 3'd7);
	assign adv    = !vld_s[9] || last_w;
	assign q_pop  = adv && q_valid;

	always_comb begin
		sel             = '0;
		sel.half        = cnt_q[2];
		sel.point_index = cnt_q[1:0];
		sel.ok          = 1'b1;
		sel.last        = last_w;
		unique case (cnt_q)
			3'd0: {sel.point_y, sel.point_x} = side_s[9].p0;
			3'd1: {sel.point_y, sel.point_x} = side_s[9].a1;
			3'd2: {sel.point_y, sel.point_x} = side_s[9].a2;
			3'd3: {sel.point_y, sel.point_x} = m_w;
			3'd4: {sel.point_y, sel.point_x} = m_w;
			3'd5: {sel.point_y, sel.point_x} = side_s[9].b2;
			3'd6: {sel.point_y, sel.point_x} = side_s[9].c1;
			3'd7: {sel.point_y, sel.point_x} = side_s[9].p3;
			default: sel.point_x = '0;
		endcase
		if (!side_s[9].ok) begin
			sel      = '0;
			sel.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s0   <= q_data;
			side_s[1] <= side_in;
			for (int k = 2; k <= 9; k++) begin
				side_s[k] <= side_nx[k];
			end
		end
		point_q <= sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s         <= '0;
			cnt_q         <= '0;
			point_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s <= {vld_s[8:0], q_valid};
			end
			if (vld_s[9]) begin
				cnt_q <= last_w ? 3'd0 : cnt_q + 3'd1;
			end
			point_valid_q <= vld_s[9];
		end
	end

	assign point_valid = point_valid_q;
	assign point       = point_q;

	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid_q && !point_q.last) |=> point_valid_q)
		else $error("gap inside a run of results");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid_q && !point_q.last) |=> (point_q.ok &&
		{point_q.half, point_q.point_index} ==
		$past({point_q.half, point_q.point_index}) + 3'd1))
		else $error("results of a run out of order");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid_q && (!$past(point_valid_q) || $past(point_q.last))) |->
		(!point_q.half && point_q.point_index == 2'd0))
		else $error("run does not start at the first point");

endmodule

FILE: rtl/cubic_bezier_subdivider.sv
// Top level of the cubic Bezier subdivider: front queue plus lerp back end.
// Depends on cbsub_pkg, cbsub_front and cbsub_back.
//
// Usage: drive req with four control points and split_t (Q1.16, one at
// 65536) and raise start; the item transfers at a clock edge where start is
// high and busy is low. For 0 < split_t < one the block emits eight
// results: the first half's points 0..3, then the second half's points
// 0..3, last set on the eighth. Otherwise one result with ok low, zero
// coordinates and last set. Each result sits on point for exactly one cycle
// with point_valid high; the receiver cannot stall and must take it.
// A taken item passes the queue, item_s0, the side_s stages and point_q.
// The single-point result port sets the item rate: a valid item holds it
// for its eight results, an out-of-range one for its single result.
// The queue holds QUEUE_DEPTH items, so that many can be taken while a run
// is being emitted; busy rises when it is full.
// Reset clears the queue, the pipeline valid bits and the emit counter;
// results start only from items taken after reset.
module cubic_bezier_subdivider import cbsub_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  req_t   req,
	output logic   busy,
	output logic   point_valid,
	output point_t point
);

	logic  q_valid;
	logic  q_pop;
	qent_t q_data;

	cbsub_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk,
		.arst_n,
		.start,
		.req,
		.busy,
		.pop     (q_pop),
		.q_valid (q_valid),
		.q_data  (q_data)
	);

	cbsub_back u_back (
		.clk,
		.arst_n,
		.q_valid,
		.q_data,
		.q_pop,
		.point_valid,
		.point
	);

endmodule
